[sv/tsrs_pkg.sv]
// package for the two-stack rotate / swap / push core
// entry and result types, action and state codes, default sizes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tsrs_pkg;

  localparam int unsigned CAPACITY_DEF = 512;
  localparam int unsigned SIZE_W_DEF   = $clog2(CAPACITY_DEF + 1);

  // one ring entry, packed rank:value
  typedef struct packed {
    logic [8:0]         rank;
    logic signed [31:0] value;
  } entry_t;

  // action codes of the input word, codes above append do nothing
  typedef enum logic [2:0] {
    ACT_ROTATE     = 3'd0,
    ACT_REV_ROTATE = 3'd1,
    ACT_SWAP       = 3'd2,
    ACT_PUSH       = 3'd3,
    ACT_APPEND     = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE2,
    ST_DONE
  } state_t;

  // which cached top takes the ring read data when the action finishes
  typedef enum logic [1:0] {
    CAP_NONE,
    CAP_A,
    CAP_B
  } cap_t;

  // fixed-width part of a result word
  typedef struct packed {
    logic [3:0] echoed_code;
    logic       ignored;
    entry_t     a_top;
    entry_t     b_top;
  } res_t;

endpackage

`default_nettype wire

[sv/tsrs_in_if.sv]
// input channel of the two-stack core: valid/ready plus one action word
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface tsrs_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic               stack_select;
  logic [3:0]         report_code;
  logic signed [31:0] entry_value;
  logic [8:0]         entry_rank;

  modport source (
    output valid, action, stack_select, report_code, entry_value, entry_rank,
    input  ready
  );
  modport sink (
    input  valid, action, stack_select, report_code, entry_value, entry_rank,
    output ready
  );
endinterface

`default_nettype wire

[sv/tsrs_out_if.sv]
// result channel of the two-stack core: valid/ready plus one result word
// depends on tsrs_pkg for the default size width
`timescale 1ns / 1ps
`default_nettype none

interface tsrs_out_if #(
  parameter int unsigned SIZE_W = tsrs_pkg::SIZE_W_DEF
);
  logic               valid;
  logic               ready;
  logic [3:0]         echoed_code;
  logic               ignored;
  logic signed [31:0] a_top_value;
  logic [8:0]         a_top_rank;
  logic signed [31:0] b_top_value;
  logic [8:0]         b_top_rank;
  logic [SIZE_W-1:0]  a_size;
  logic [SIZE_W-1:0]  b_size;

  modport source (
    output valid, echoed_code, ignored, a_top_value, a_top_rank,
           b_top_value, b_top_rank, a_size, b_size,
    input  ready
  );
  modport sink (
    input  valid, echoed_code, ignored, a_top_value, a_top_rank,
           b_top_value, b_top_rank, a_size, b_size,
    output ready
  );
endinterface

`default_nettype wire

[sv/tsrs_ring_mem.sv]
// ring store of one stack: one write port, one registered read port
// read-first on a same-address collision; depends on tsrs_pkg
`timescale 1ns / 1ps
`default_nettype none

module tsrs_ring_mem #(
  parameter int unsigned DEPTH = tsrs_pkg::CAPACITY_DEF,
  parameter int unsigned IW    = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [IW-1:0]         rd_addr,
  output tsrs_pkg::entry_t      rd_data,
  input  logic                  wr_en,
  input  logic [IW-1:0]         wr_addr,
  input  tsrs_pkg::entry_t      wr_data
);
  import tsrs_pkg::*;

  entry_t ring_r [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= ring_r[rd_addr];
    end
    if (wr_en) begin
      ring_r[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[sv/tsrs_out_reg.sv]
// result register of the two-stack core, parts the core from the result sink
// depends on tsrs_pkg and tsrs_out_if
`timescale 1ns / 1ps
`default_nettype none

module tsrs_out_reg #(
  parameter int unsigned SIZE_W = tsrs_pkg::SIZE_W_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  tsrs_pkg::res_t    res,
  input  logic [SIZE_W-1:0] a_size,
  input  logic [SIZE_W-1:0] b_size,
  output logic              free,
  tsrs_out_if.source        out_chan
);
  import tsrs_pkg::*;

  logic              valid_r;
  res_t              res_r;
  logic [SIZE_W-1:0] a_size_r;
  logic [SIZE_W-1:0] b_size_r;

  // slot can take a word when empty or when its word leaves this cycle
  assign free = !valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r    <= res;
      a_size_r <= a_size;
      b_size_r <= b_size;
    end
  end

  assign out_chan.valid       = valid_r;
  assign out_chan.echoed_code = res_r.echoed_code;
  assign out_chan.ignored     = res_r.ignored;
  assign out_chan.a_top_value = res_r.a_top.value;
  assign out_chan.a_top_rank  = res_r.a_top.rank;
  assign out_chan.b_top_value = res_r.b_top.value;
  assign out_chan.b_top_rank  = res_r.b_top.rank;
  assign out_chan.a_size      = a_size_r;
  assign out_chan.b_size      = b_size_r;

endmodule

`default_nettype wire

[sv/two_stack_rotate_swap_push_core.sv]
// top level of the two-stack rotate / swap / push core
// depends on tsrs_pkg, tsrs_in_if, tsrs_out_if, tsrs_ring_mem, tsrs_out_reg
`timescale 1ns / 1ps
`default_nettype none

//  channel   dir  handshake        word
//  in_chan   in   valid / ready    action, stack_select, report_code, entry_value, entry_rank
//  out_chan  out  valid / ready    echoed_code, ignored, a/b top value and rank, a/b size
//
//  the result word loads in the done state, reached straight from the accept or, for reverse rotate
//  and a real swap, through a second-write state (single write port per ring memory, registered
//  read); ready returns the cycle after the load.
//  synchronous active-low reset clears pointers, fills and control; ring contents are not
//  cleared, only entries inside the fill are ever read.
//  a stalled result sink holds the finished action until the result register frees up.

module two_stack_rotate_swap_push_core #(
  parameter int unsigned CAPACITY = tsrs_pkg::CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tsrs_in_if.sink    in_chan,
  tsrs_out_if.source out_chan
);
  import tsrs_pkg::*;

  localparam int unsigned IW     = $clog2(CAPACITY);
  localparam int unsigned FW     = $clog2(CAPACITY + 1);
  localparam logic [FW-1:0] CAP_F  = FW'(CAPACITY);
  localparam logic [FW-1:0] ONE_F  = FW'(1);
  localparam logic [FW-1:0] BACK_F = FW'(CAPACITY - 1);

  // index h + d wrapped into the ring, d never above the capacity where the result is used
  function automatic logic [IW-1:0] wrap_sum(input logic [IW-1:0] h, input logic [FW-1:0] d);
    logic [FW:0] s;
    s = (FW+1)'(h) + (FW+1)'(d);
    if (s >= (FW+1)'(CAPACITY)) begin
      s = s - (FW+1)'(CAPACITY);
    end
    return s[IW-1:0];
  endfunction

  // architectural state
  state_t        state_r, state_nxt;
  logic [IW-1:0] a_head_r, a_head_nxt;
  logic [IW-1:0] b_head_r, b_head_nxt;
  logic [FW-1:0] a_fill_r, a_fill_nxt;
  logic [FW-1:0] b_fill_r, b_fill_nxt;
  entry_t        a_top_r, a_top_nxt;     // cached copy of ring[head]
  entry_t        b_top_r, b_top_nxt;

  // per-action context
  logic          sel_r, sel_nxt;
  cap_t          cap_r, cap_nxt;
  logic [IW-1:0] wr2_addr_r, wr2_addr_nxt;
  logic [3:0]    echo_r, echo_nxt;
  logic          ign_r, ign_nxt;

  // ring memory ports
  logic          a_rd_en, a_wr_en, b_rd_en, b_wr_en;
  logic [IW-1:0] a_rd_addr, a_wr_addr, b_rd_addr, b_wr_addr;
  entry_t        a_rd_data, a_wr_data, b_rd_data, b_wr_data;

  // decode of the incoming word, x is the acted-on stack, y the other one
  logic          accept;
  act_t          act;
  logic          eff_sel;
  logic          stack_act;
  entry_t        in_entry;
  logic [IW-1:0] x_head, y_head;
  logic [FW-1:0] x_fill, y_fill;
  entry_t        x_top;
  logic [IW-1:0] x_inc, x_dec, x_tail, x_bot, y_dec;

  // x/y working values of the accept cycle
  logic          done;
  logic [IW-1:0] xh_n, yh_n;
  logic [FW-1:0] xf_n, yf_n;
  entry_t        xt_n, yt_n;
  logic          x_rd_en, x_wr_en, y_wr_en;
  logic [IW-1:0] x_rd_addr, x_wr_addr, y_wr_addr;
  entry_t        x_wr_data, y_wr_data;

  // result side
  logic          out_free;
  logic          out_load;
  res_t          res;
  logic [FW:0]   fill_sum;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign act           = act_t'(in_chan.action);
  // append always works on A
  assign eff_sel       = (act == ACT_APPEND) ? 1'b0 : in_chan.stack_select;
  assign stack_act     = act inside {ACT_ROTATE, ACT_REV_ROTATE, ACT_SWAP, ACT_PUSH};
  assign in_entry      = '{rank: in_chan.entry_rank, value: in_chan.entry_value};

  assign x_head = eff_sel ? b_head_r : a_head_r;
  assign x_fill = eff_sel ? b_fill_r : a_fill_r;
  assign x_top  = eff_sel ? b_top_r  : a_top_r;
  assign y_head = eff_sel ? a_head_r : b_head_r;
  assign y_fill = eff_sel ? a_fill_r : b_fill_r;

  assign x_inc  = wrap_sum(x_head, ONE_F);
  assign x_dec  = wrap_sum(x_head, BACK_F);
  assign x_tail = wrap_sum(x_head, x_fill);
  assign x_bot  = wrap_sum(x_head, x_fill - ONE_F);
  assign y_dec  = wrap_sum(y_head, BACK_F);

  // accept-cycle work on the selected stack
  always_comb begin
    done      = 1'b0;
    ign_nxt   = 1'b0;
    cap_nxt   = CAP_NONE;
    wr2_addr_nxt = wr2_addr_r;
    xh_n      = x_head;
    xf_n      = x_fill;
    xt_n      = x_top;
    yh_n      = y_head;
    yf_n      = y_fill;
    yt_n      = eff_sel ? a_top_r : b_top_r;
    x_rd_en   = 1'b0;
    x_rd_addr = x_inc;
    x_wr_en   = 1'b0;
    x_wr_addr = x_tail;
    x_wr_data = x_top;
    y_wr_en   = 1'b0;
    y_wr_addr = y_dec;
    y_wr_data = x_top;

    if (stack_act && (x_fill == '0)) begin
      ign_nxt = 1'b1;
    end else begin
      unique case (act)
        ACT_ROTATE: begin
          // old top goes behind the bottom, next entry becomes top
          x_wr_en   = 1'b1;
          x_wr_addr = x_tail;
          x_rd_en   = 1'b1;
          x_rd_addr = x_inc;
          xh_n      = x_inc;
          if (x_fill != ONE_F) begin
            cap_nxt = eff_sel ? CAP_B : CAP_A;
          end
          done = 1'b1;
        end
        ACT_REV_ROTATE: begin
          // fetch the bottom, written in front of the head next cycle
          x_rd_en      = 1'b1;
          x_rd_addr    = x_bot;
          wr2_addr_nxt = x_dec;
          xh_n         = x_dec;
          done         = 1'b1;
        end
        ACT_SWAP: begin
          // read-first: second entry comes out while the old top goes in
          if (x_fill != ONE_F) begin
            x_rd_en      = 1'b1;
            x_rd_addr    = x_inc;
            x_wr_en      = 1'b1;
            x_wr_addr    = x_inc;
            wr2_addr_nxt = x_head;
          end
          done = 1'b1;
        end
        ACT_PUSH: begin
          if (y_fill == CAP_F) begin
            ign_nxt = 1'b1;
          end else begin
            y_wr_en = 1'b1;
            yh_n    = y_dec;
            yf_n    = y_fill + ONE_F;
            yt_n    = x_top;
            xh_n    = x_inc;
            xf_n    = x_fill - ONE_F;
            if (x_fill != ONE_F) begin
              x_rd_en   = 1'b1;
              x_rd_addr = x_inc;
              cap_nxt   = eff_sel ? CAP_B : CAP_A;
            end
            done = 1'b1;
          end
        end
        ACT_APPEND: begin
          if (x_fill == CAP_F) begin
            ign_nxt = 1'b1;
          end else begin
            x_wr_en   = 1'b1;
            x_wr_addr = x_tail;
            x_wr_data = in_entry;
            xf_n      = x_fill + ONE_F;
            if (x_fill == '0) begin
              xt_n = in_entry;
            end
            done = 1'b1;
          end
        end
        default: begin
          // unused action codes leave everything alone
        end
      endcase
    end
    echo_nxt = done ? in_chan.report_code : 4'd0;
  end

  // sequencer, pointer updates and memory port steering
  always_comb begin
    state_nxt  = state_r;
    a_head_nxt = a_head_r;
    b_head_nxt = b_head_r;
    a_fill_nxt = a_fill_r;
    b_fill_nxt = b_fill_r;
    a_top_nxt  = a_top_r;
    b_top_nxt  = b_top_r;
    sel_nxt    = sel_r;
    a_rd_en    = 1'b0;
    a_rd_addr  = x_rd_addr;
    a_wr_en    = 1'b0;
    a_wr_addr  = x_wr_addr;
    a_wr_data  = x_wr_data;
    b_rd_en    = 1'b0;
    b_rd_addr  = x_rd_addr;
    b_wr_en    = 1'b0;
    b_wr_addr  = x_wr_addr;
    b_wr_data  = x_wr_data;
    out_load   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          sel_nxt = eff_sel;
          if (eff_sel) begin
            b_head_nxt = xh_n;
            b_fill_nxt = xf_n;
            b_top_nxt  = xt_n;
            a_head_nxt = yh_n;
            a_fill_nxt = yf_n;
            a_top_nxt  = yt_n;
            b_rd_en    = x_rd_en;
            b_wr_en    = x_wr_en;
            a_wr_en    = y_wr_en;
            a_wr_addr  = y_wr_addr;
            a_wr_data  = y_wr_data;
          end else begin
            a_head_nxt = xh_n;
            a_fill_nxt = xf_n;
            a_top_nxt  = xt_n;
            b_head_nxt = yh_n;
            b_fill_nxt = yf_n;
            b_top_nxt  = yt_n;
            a_rd_en    = x_rd_en;
            a_wr_en    = x_wr_en;
            b_wr_en    = y_wr_en;
            b_wr_addr  = y_wr_addr;
            b_wr_data  = y_wr_data;
          end
          // reverse rotate and a real swap need a second write
          state_nxt = (wr2_addr_nxt != wr2_addr_r || x_rd_en) &&
                      (act == ACT_REV_ROTATE || (act == ACT_SWAP && x_wr_en)) &&
                      !ign_nxt ? ST_WRITE2 : ST_DONE;
        end
      end
      ST_WRITE2: begin
        // fetched entry becomes the new top and lands at the head slot
        if (sel_r) begin
          b_wr_en   = 1'b1;
          b_wr_addr = wr2_addr_r;
          b_wr_data = b_rd_data;
          b_top_nxt = b_rd_data;
        end else begin
          a_wr_en   = 1'b1;
          a_wr_addr = wr2_addr_r;
          a_wr_data = a_rd_data;
          a_top_nxt = a_rd_data;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (cap_r == CAP_A) begin
          a_top_nxt = a_rd_data;
        end else if (cap_r == CAP_B) begin
          b_top_nxt = b_rd_data;
        end
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      a_head_r <= '0;
      b_head_r <= '0;
      a_fill_r <= '0;
      b_fill_r <= '0;
      cap_r    <= CAP_NONE;
    end else begin
      state_r  <= state_nxt;
      a_head_r <= a_head_nxt;
      b_head_r <= b_head_nxt;
      a_fill_r <= a_fill_nxt;
      b_fill_r <= b_fill_nxt;
      if (accept) begin
        cap_r <= cap_nxt;
      end else if (state_r == ST_DONE) begin
        // top taken from the read port once, then held
        cap_r <= CAP_NONE;
      end
    end
  end

  // payload and per-action context
  always_ff @(posedge clk) begin
    a_top_r <= a_top_nxt;
    b_top_r <= b_top_nxt;
    if (accept) begin
      sel_r      <= sel_nxt;
      wr2_addr_r <= wr2_addr_nxt;
      echo_r     <= echo_nxt;
      ign_r      <= ign_nxt;
    end
  end

  tsrs_ring_mem #(
    .DEPTH (CAPACITY),
    .IW    (IW)
  ) u_ring_a (
    .clk     (clk),
    .rd_en   (a_rd_en),
    .rd_addr (a_rd_addr),
    .rd_data (a_rd_data),
    .wr_en   (a_wr_en),
    .wr_addr (a_wr_addr),
    .wr_data (a_wr_data)
  );

  tsrs_ring_mem #(
    .DEPTH (CAPACITY),
    .IW    (IW)
  ) u_ring_b (
    .clk     (clk),
    .rd_en   (b_rd_en),
    .rd_addr (b_rd_addr),
    .rd_data (b_rd_data),
    .wr_en   (b_wr_en),
    .wr_addr (b_wr_addr),
    .wr_data (b_wr_data)
  );

  // result word shows the state after the action, empty tops read as zero
  always_comb begin
    res.echoed_code = echo_r;
    res.ignored     = ign_r;
    res.a_top       = (a_fill_nxt != '0) ? a_top_nxt : '0;
    res.b_top       = (b_fill_nxt != '0) ? b_top_nxt : '0;
  end

  tsrs_out_reg #(
    .SIZE_W (FW)
  ) u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (out_load),
    .res      (res),
    .a_size   (a_fill_nxt),
    .b_size   (b_fill_nxt),
    .free     (out_free),
    .out_chan (out_chan)
  );

  assign fill_sum = (FW+1)'(a_fill_r) + (FW+1)'(b_fill_r);

  // fills never pass the ring depth
  assert property (@(posedge clk) disable iff (!rst_n)
    (a_fill_r <= CAP_F) && (b_fill_r <= CAP_F))
    else $error("fill count beyond ring depth");

  // only append changes the total number of entries
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_chan.action != ACT_APPEND)) |=> (fill_sum == $past(fill_sum)))
    else $error("entries created or lost by a stack action");

  // a pending top capture always targets a stack that still holds entries
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> ((cap_r != CAP_A || a_fill_r != '0) &&
                              (cap_r != CAP_B || b_fill_r != '0)))
    else $error("top captured for an empty stack");

  // the second write state is always followed by the result state
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE2) |=> (state_r == ST_DONE))
    else $error("second write stage not followed by result stage");

  // an ignored action never echoes its code
  assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !(res.ignored && (res.echoed_code != 4'd0)))
    else $error("ignored action echoed a report code");

endmodule

`default_nettype wire
